>>> hw/rtl/msr_pkg.sv
// types, constants and codes shared by the speed ramp generator
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

	localparam int CHANNELS   = 3;
	localparam int NUM_MOTORS = 3;

	localparam int SPEED_W = 8;
	localparam int STEP_W  = 7;
	localparam int TICK_W  = 8;
	localparam int CIDX_W  = 2;
	localparam int CDAT_W  = 8;

	localparam logic [STEP_W-1:0] STEP_RESET  = 7'd5;
	localparam logic [TICK_W-1:0] TICKS_RESET = 8'd10;

	typedef enum logic {
		REQ_SET  = 1'b0,
		REQ_TICK = 1'b1
	} req_type_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_STEP_SIZE      = 2'd0,
		REG_TICKS_PER_STEP = 2'd1
	} reg_index_t;

	typedef logic signed [SPEED_W-1:0] speed_t;

	// effective configuration, zero values already mapped to one
	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [TICK_W-1:0] limit;
	} cfg_t;

	// per-channel step outcome
	typedef struct packed {
		speed_t speed;
		logic   moved;
		logic   busy;
	} chan_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/msr_cfg_regs.sv
// configuration registers of the speed ramp generator
`timescale 1ns / 1ps
`default_nettype none

module msr_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [msr_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [msr_pkg::CDAT_W-1:0] cfg_data,
	output msr_pkg::cfg_t                   cfg
);
	import msr_pkg::*;

	logic [STEP_W-1:0] step_size_q;
	logic [TICK_W-1:0] ticks_per_step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q      <= STEP_RESET;
			ticks_per_step_q <= TICKS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STEP_SIZE:      step_size_q      <= cfg_data[STEP_W-1:0];
				REG_TICKS_PER_STEP: ticks_per_step_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.step  = (step_size_q == '0) ? STEP_W'(1) : step_size_q;
		cfg.limit = (ticks_per_step_q == '0) ? TICK_W'(1) : ticks_per_step_q;
	end

endmodule

`default_nettype wire

>>> hw/rtl/msr_chan_step.sv
// one ramp step of a single channel
`timescale 1ns / 1ps
`default_nettype none

module msr_chan_step (
	input  wire msr_pkg::speed_t            cur,
	input  wire msr_pkg::speed_t            tgt,
	input  wire logic [msr_pkg::STEP_W-1:0] step,
	input  wire logic                       do_step,
	output msr_pkg::chan_res_t              res
);
	import msr_pkg::*;

	logic signed [SPEED_W:0] gap;
	logic [SPEED_W:0]        mag;
	logic [SPEED_W-1:0]      step_ext;
	speed_t                  stepped;

	always_comb begin
		gap      = {tgt[SPEED_W-1], tgt} - {cur[SPEED_W-1], cur};
		mag      = gap[SPEED_W] ? -gap : gap;
		step_ext = {1'b0, step};
		if (mag <= {2'b00, step})
			stepped = tgt;
		else if (gap[SPEED_W])
			stepped = cur - step_ext;
		else
			stepped = cur + step_ext;

		res.moved = do_step && (gap != '0);
		res.speed = res.moved ? stepped : cur;
		res.busy  = (res.speed != tgt);
	end

endmodule

`default_nettype wire

>>> hw/rtl/multi_motor_speed_ramp_core.sv
// Three-channel speed ramp generator (slew-rate limiter). Takes one transfer per
// clock while the output is not stalled, and returns one result per transfer through
// an input register, then the step logic feeding the state and the output register.
// A set transfer loads the three signed targets and steps at once; a tick transfer
// counts, and every ticks_per_step ticks does a step. A step moves each channel by
// at most step_size toward its target. Zero register values act as 1. The user must
// write configuration via cfg_* only with no transfer in flight; nothing enforces it.
`timescale 1ns / 1ps
`default_nettype none

module multi_motor_speed_ramp_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [msr_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [msr_pkg::CDAT_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        req_type,
	input  wire logic signed [7:0]           target_a,
	input  wire logic signed [7:0]           target_b,
	input  wire logic signed [7:0]           target_c,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [7:0]                speed_a,
	output logic signed [7:0]                speed_b,
	output logic signed [7:0]                speed_c,
	output logic                             updated,
	output logic                             busy_res
);
	import msr_pkg::*;

	cfg_t cfg;

	msr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input stage
	logic       valid_s1;
	logic       req_s1;
	speed_t     tgt_in_s1 [CHANNELS];
	logic       adv_s1;
	logic       out_valid_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1       <= req_type;
			tgt_in_s1[0] <= target_a;
			tgt_in_s1[1] <= target_b;
			tgt_in_s1[2] <= target_c;
		end
	end

	// ramp state
	speed_t            cur_q [CHANNELS];
	speed_t            tgt_q [CHANNELS];
	logic [TICK_W-1:0] tick_q;

	logic              is_set;
	logic [TICK_W-1:0] tick_inc;
	logic              tick_hit;
	logic              do_step;
	logic [TICK_W-1:0] tick_d;

	always_comb begin
		is_set   = (req_s1 == REQ_SET);
		tick_inc = tick_q + TICK_W'(1);
		tick_hit = (tick_inc >= cfg.limit);
		do_step  = is_set || tick_hit;
		tick_d   = (is_set || tick_hit) ? '0 : tick_inc;
	end

	speed_t    tgt_d   [CHANNELS];
	chan_res_t chan_res [CHANNELS];
	logic [CHANNELS-1:0] moved_v;
	logic [CHANNELS-1:0] busy_v;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		if (i < NUM_MOTORS) begin : g_used
			assign tgt_d[i] = is_set ? tgt_in_s1[i] : tgt_q[i];
			msr_chan_step u_step (
				.cur     (cur_q[i]),
				.tgt     (tgt_d[i]),
				.step    (cfg.step),
				.do_step (do_step),
				.res     (chan_res[i])
			);
		end else begin : g_unused
			assign tgt_d[i]    = '0;
			assign chan_res[i] = '0;
		end
		assign moved_v[i] = chan_res[i].moved;
		assign busy_v[i]  = chan_res[i].busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i] <= '0;
				tgt_q[i] <= '0;
			end
		end else if (adv_s1) begin
			tick_q <= tick_d;
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i] <= chan_res[i].speed;
				tgt_q[i] <= tgt_d[i];
			end
		end
	end

	// output register
	speed_t speed_q [CHANNELS];
	logic   updated_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < CHANNELS; i++)
				speed_q[i] <= chan_res[i].speed;
			updated_q <= |moved_v;
			busy_q    <= |busy_v;
		end
	end

	assign out_valid = out_valid_q;
	assign speed_a   = speed_q[0];
	assign speed_b   = speed_q[1];
	assign speed_c   = speed_q[2];
	assign updated   = updated_q;
	assign busy_res  = busy_q;

	// checks
	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q != {TICK_W{1'b1}})
		else $error("tick counter reached an impossible value");

	a_set_clears_tick: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && is_set |=> tick_q == '0)
		else $error("set transfer did not restart the tick counter");

	a_idle_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !busy_q |-> speed_q[0] == tgt_q[0] && speed_q[0] == cur_q[0])
		else $error("result reports idle while a gap remains");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |=> valid_s1 && $stable(tick_q))
		else $error("input stage advanced while the result was stalled");

endmodule

`default_nettype wire
